// ===== rtl/core/hkrb_pkg.sv =====
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types and constants for the HID keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    localparam int KEY_SLOTS    = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int IDX_W        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W        = $clog2(KEY_SLOTS + 1);

    localparam logic [7:0] ROLLOVER_CODE = 8'h01;
    localparam logic [7:0] NO_USAGE      = 8'h00;

    typedef logic [7:0] t_usage;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_usage           wr_data;
        logic             cnt_inc;
        logic             cnt_dec;
        logic [IDX_W-1:0] rd_idx;
    } t_list_cmd;

    typedef struct packed {
        t_usage           rd_data;
        logic [CNT_W-1:0] count;
    } t_list_stat;

endpackage

// ===== rtl/core/hkrb_key_list.sv =====
// ----------------------------------------------------------------------------
// hkrb_key_list
// Ordered list of held usages with one read port, one write port, a fill
// count and the fixed report view of the first slots.
// ----------------------------------------------------------------------------
module hkrb_key_list
    import hkrb_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_list_cmd                   i_cmd,
    output t_list_stat                  o_stat,
    output t_usage [REPORT_SLOTS-1:0]   o_slots
);

    t_usage           r_keys [KEY_SLOTS];
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_keys[k] <= NO_USAGE;
            end
            r_count <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_keys[i_cmd.wr_idx] <= i_cmd.wr_data;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.count   = r_count;
        o_stat.rd_data = NO_USAGE;
        if (32'(i_cmd.rd_idx) < KEY_SLOTS) begin
            o_stat.rd_data = r_keys[i_cmd.rd_idx];
        end
    end

    for (genvar j = 0; j < REPORT_SLOTS; j++) begin : g_slot
        if (j < KEY_SLOTS) begin : g_live
            assign o_slots[j] = (CNT_W'(j) < r_count) ? r_keys[j] : NO_USAGE;
        end else begin : g_pad
            assign o_slots[j] = NO_USAGE;
        end
    end

endmodule

// ===== rtl/core/hkrb_seq.sv =====
// ----------------------------------------------------------------------------
// hkrb_seq
// Event sequencer: for an ordinary key, one compare per cycle scans the held
// list, then appends, closes the gap one entry per cycle, or leaves the list
// unchanged. Holds modifier and rollover state.
// ----------------------------------------------------------------------------
module hkrb_seq
    import hkrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_key_pressed,
    input  logic        i_is_modifier,
    input  logic [2:0]  i_modifier_bit,
    input  t_usage      i_key_usage,
    input  logic        i_out_free,
    input  t_list_stat  i_stat,
    output t_list_cmd   o_cmd,
    output logic        o_ready,
    output logic        o_done,
    output logic [7:0]  o_mods,
    output logic        o_rollover
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       r_state,    n_state;
    logic [CNT_W-1:0] r_pos,      n_pos;
    logic             r_down,     n_down;
    t_usage           r_usage,    n_usage;
    logic             r_rollover, n_rollover;
    logic [7:0]       r_mods,     n_mods;
    logic [CNT_W-1:0] w_next;

    assign w_next = r_pos + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_down     = r_down;
        n_usage    = r_usage;
        n_rollover = r_rollover;
        n_mods     = r_mods;
        o_cmd      = '0;
        o_cmd.rd_idx = r_pos[IDX_W-1:0];
        o_done     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_down  = i_key_pressed;
                    n_usage = i_key_usage;
                    n_pos   = '0;
                    if (i_is_modifier) begin
                        if (i_key_pressed) begin
                            n_mods = r_mods | (8'd1 << i_modifier_bit);
                        end else begin
                            n_mods = r_mods & ~(8'd1 << i_modifier_bit);
                        end
                        n_state = S_DONE;
                    end else if (i_key_usage == NO_USAGE) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pos == i_stat.count) begin
                    if (r_down) begin
                        if (32'(i_stat.count) < KEY_SLOTS) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_idx  = i_stat.count[IDX_W-1:0];
                            o_cmd.wr_data = r_usage;
                            o_cmd.cnt_inc = 1'b1;
                            n_rollover    = 1'b0;
                        end else begin
                            n_rollover = 1'b1;
                        end
                    end else begin
                        n_rollover = 1'b0;
                    end
                    n_state = S_DONE;
                end else if (i_stat.rd_data == r_usage) begin
                    n_state = r_down ? S_DONE : S_SHIFT;
                end else begin
                    n_pos = w_next;
                end
            end
            S_SHIFT: begin
                o_cmd.rd_idx = w_next[IDX_W-1:0];
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_idx = r_pos[IDX_W-1:0];
                if (w_next < i_stat.count) begin
                    o_cmd.wr_data = i_stat.rd_data;
                    n_pos         = w_next;
                end else begin
                    o_cmd.wr_data = NO_USAGE;
                    o_cmd.cnt_dec = 1'b1;
                    n_rollover    = 1'b0;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rollover <= 1'b0;
            r_mods     <= '0;
            r_pos      <= '0;
        end else begin
            r_state    <= n_state;
            r_rollover <= n_rollover;
            r_mods     <= n_mods;
            r_pos      <= n_pos;
        end
        r_down  <= n_down;
        r_usage <= n_usage;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_mods     = r_mods;
    assign o_rollover = r_rollover;

endmodule

// ===== rtl/core/hid_keyboard_report_builder_top.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_top
// Six-key-rollover boot keyboard report builder: one key event in, one
// boot report out.
//
// channel  dir  tdata                                         tuser
// s_axis   in   key_pressed, modifier_bit, key_usage          is_modifier
// m_axis   out  modifier_byte, slot_one .. slot_six           -
//
// Modifier and usage-zero events skip the scan; ordinary keys scan the held
// list one entry per cycle through a single compare, and a release closes
// the gap from the match one entry per cycle.
// Reset clears modifiers, the held list, its count and the rollover flag.
// A new item is taken while the last report still waits in the output
// register; a stalled output holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_top
    import hkrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // key_pressed[0], modifier_bit[3:1], key_usage[11:4]
    input  logic        i_s_tuser,  // is_modifier[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata   // modifier_byte[7:0], slot_one[15:8] .. slot_six[55:48]
);

    t_list_cmd                  w_cmd;
    t_list_stat                 w_stat;
    t_usage [REPORT_SLOTS-1:0]  w_slots;
    logic                       w_start;
    logic                       w_done;
    logic                       w_out_free;
    logic [7:0]                 w_mods;
    logic                       w_rollover;
    logic [55:0]                w_report;

    logic                       r_out_valid;
    logic [55:0]                r_out_data;

    assign w_start    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    hkrb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_key_pressed  (i_s_tdata[0]),
        .i_is_modifier  (i_s_tuser),
        .i_modifier_bit (i_s_tdata[3:1]),
        .i_key_usage    (i_s_tdata[11:4]),
        .i_out_free     (w_out_free),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_ready        (o_s_tready),
        .o_done         (w_done),
        .o_mods         (w_mods),
        .o_rollover     (w_rollover)
    );

    hkrb_key_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_slots (w_slots)
    );

    always_comb begin
        w_report[7:0] = w_mods;
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            w_report[8*(j+1) +: 8] = w_rollover ? ROLLOVER_CODE : w_slots[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_data <= w_report;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_s_tready)
        else $error("item accepted while sequencer busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_stat.count) <= KEY_SLOTS)
        else $error("held count above slot limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!r_out_valid || i_m_tready))
        else $error("report overwrote a pending item");

    a_one_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> !w_done)
        else $error("two reports for one item");

endmodule

// ===== verif/hid_keyboard_report_builder_top_tb.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_top_tb
// Drives key events into the report builder and checks every boot report
// against a cycle-free model of the modifier bits, held-key list and rollover
// flag, or a directed row's typed report. A short directed table comes first,
// then random typing over a small key pool, with random stalls on both streams.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_top_tb;
    import hkrb_pkg::*;

    typedef struct packed {
        logic [5:0][7:0] slots;
        logic [7:0]      mods;
    } t_report;

    typedef struct packed {
        logic        pressed;
        logic        is_mod;
        logic [2:0]  mbit;
        logic [7:0]  usage;
        logic        typed;
        logic [55:0] rpt;
    } t_dir_row;

    localparam int DIR_ROWS   = 25;
    localparam int RAND_ITEMS = 1300;
    localparam int CALM_FROM  = 1150;
    localparam int PAUSE_AT   = 600;
    localparam int DRAIN_CYC  = 2 + 2 * KEY_SLOTS + 8;

    // pressed, is_mod, mbit, usage, typed, report {slot_six .. slot_one, mods}
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{1'b1, 1'b0, 3'd0, 8'h00, 1'b1, 56'h00_0000_0000_0000},
        '{1'b1, 1'b1, 3'd0, 8'h00, 1'b1, 56'h00_0000_0000_0001},
        '{1'b1, 1'b1, 3'd7, 8'h00, 1'b1, 56'h00_0000_0000_0081},
        '{1'b0, 1'b1, 3'd7, 8'h00, 1'b1, 56'h00_0000_0000_0001},
        '{1'b1, 1'b0, 3'd0, 8'h04, 1'b1, 56'h00_0000_0000_0401},
        '{1'b1, 1'b0, 3'd0, 8'h04, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'hFF, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'h05, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'h06, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'h07, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'h08, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'h09, 1'b1, 56'h01_0101_0101_0101},
        '{1'b0, 1'b0, 3'd0, 8'h00, 1'b0, 56'h0},
        '{1'b1, 1'b1, 3'd3, 8'h00, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h0A, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h05, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h04, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h08, 1'b0, 56'h0},
        '{1'b1, 1'b0, 3'd0, 8'h01, 1'b0, 56'h0},
        '{1'b0, 1'b1, 3'd0, 8'hFF, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd7, 8'h07, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'hFF, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h06, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h01, 1'b0, 56'h0},
        '{1'b0, 1'b0, 3'd0, 8'h80, 1'b1, 56'h00_0000_0000_0008}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // key_pressed[0], modifier_bit[3:1], key_usage[11:4]
    logic        i_s_tuser  = 1'b0; // is_modifier[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;         // modifier_byte[7:0], slot_one[15:8] .. slot_six[55:48]

    logic [7:0] kb_mods;
    logic [7:0] kb_held [KEY_SLOTS];
    int         kb_count;
    logic       kb_rollover;

    t_report pending_reports [$];
    int      mismatches = 0;
    bit      calm       = 1'b0;
    int      stall_left = 0;

    hid_keyboard_report_builder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_report apply_key_event(input logic pressed, input logic is_mod,
                                                input logic [2:0] mbit,
                                                input logic [7:0] usage);
        int      pos;
        t_report r;
        pos = -1;
        if (is_mod) begin
            kb_mods[mbit] = pressed;
        end else if (usage != NO_USAGE) begin
            for (int i = 0; i < kb_count; i++)
                if (pos < 0 && kb_held[i] == usage) pos = i;
            if (pressed) begin
                if (pos < 0) begin
                    if (kb_count < KEY_SLOTS) begin
                        kb_held[kb_count] = usage;
                        kb_count++;
                        kb_rollover = 1'b0;
                    end else begin
                        kb_rollover = 1'b1;
                    end
                end
            end else begin
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < kb_count; i++)
                        kb_held[i] = kb_held[i + 1];
                    kb_count--;
                    kb_held[kb_count] = NO_USAGE;
                end
                kb_rollover = 1'b0;
            end
        end
        r.mods = kb_mods;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (kb_rollover)
                r.slots[i] = ROLLOVER_CODE;
            else if (i < kb_count && i < KEY_SLOTS)
                r.slots[i] = kb_held[i];
            else
                r.slots[i] = NO_USAGE;
        end
        return r;
    endfunction

    task automatic send_key_event(input logic pressed, input logic is_mod,
                                  input logic [2:0] mbit, input logic [7:0] usage,
                                  input logic typed, input logic [55:0] typed_rpt);
        t_report pred;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, usage, mbit, pressed};
        i_s_tuser  <= is_mod;
        do @(posedge i_clk); while (!o_s_tready);
        pred = apply_key_event(pressed, is_mod, mbit, usage);
        pending_reports.insert(pending_reports.size(), typed ? t_report'(typed_rpt) : pred);
    endtask

    task automatic sender_idle();
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (o_m_tvalid && i_m_tready) begin
            got = t_report'(o_m_tdata);
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report %h", $time, o_m_tdata);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (got.mods !== want.mods) begin
                    $display("%0t: modifier_byte expected %h got %h", $time, want.mods,
                             got.mods);
                    mismatches++;
                end
                for (int i = 0; i < REPORT_SLOTS; i++)
                    if (got.slots[i] !== want.slots[i]) begin
                        $display("%0t: slot %0d expected %h got %h", $time, i + 1,
                                 want.slots[i], got.slots[i]);
                        mismatches++;
                    end
            end
        end
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic       pressed;
        logic       is_mod;
        logic [2:0] mbit;
        logic [7:0] usage;
        int         r;

        kb_mods     = '0;
        kb_count    = 0;
        kb_rollover = 1'b0;
        foreach (kb_held[i]) kb_held[i] = NO_USAGE;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS; n++) begin
            sender_idle();
            send_key_event(DIR_TABLE[n].pressed, DIR_TABLE[n].is_mod, DIR_TABLE[n].mbit,
                           DIR_TABLE[n].usage, DIR_TABLE[n].typed, DIR_TABLE[n].rpt);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= CALM_FROM);
            if (n == PAUSE_AT) begin
                i_s_tvalid <= 1'b0;
                while (pending_reports.size() != 0) @(posedge i_clk);
            end
            sender_idle();
            mbit   = 3'($urandom_range(0, 7));
            usage  = 8'($urandom_range(0, 255));
            is_mod = ($urandom_range(0, 3) == 0);
            r      = $urandom_range(0, 19);
            // mostly typing over a small pool so the list fills and rolls over
            if (!is_mod) begin
                pressed = ($urandom_range(0, 99) < 55);
                if (!pressed && kb_count > 0 && r < 14)
                    usage = kb_held[$urandom_range(0, kb_count - 1)];
                else if (r < 16)
                    usage = 8'($urandom_range(1, 10));
                else if (r == 19)
                    usage = NO_USAGE;
            end else begin
                pressed = 1'($urandom_range(0, 1));
            end
            send_key_event(pressed, is_mod, mbit, usage, 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
